### rtl/core/lod_pkg.sv
// Shared types, widths and status codes of the lock order deadlock checker.
`timescale 1ns / 1ps
`default_nettype none

package lod_pkg;

   // Fixed field widths of the transaction payloads.
   localparam int CMD_W    = 1;
   localparam int THREAD_W = 3;
   localparam int KEY_W    = 4;
   localparam int STATUS_W = 3;

   // Default sizing.
   localparam int LOD_NUM_LOCKS   = 16;
   localparam int LOD_NUM_THREADS = 8;
   localparam int LOD_STACK_DEPTH = 16;

   localparam logic CMD_ACQUIRE = 1'b0;
   localparam logic CMD_RELEASE = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK          = 3'd0,
      ST_RELOCK      = 3'd1,
      ST_CYCLE       = 3'd2,
      ST_POP_EMPTY   = 3'd3,
      ST_POP_NOT_TOP = 3'd4,
      ST_FULL        = 3'd5,
      ST_HALTED      = 3'd6
   } status_type;

   // Sequencer to graph unit.
   typedef struct packed {
      logic set_edge;
      logic walk_start;
      logic walk_step;
   } graph_ctl_type;

   // Graph unit to sequencer.
   typedef struct packed {
      logic edge_known;
      logic found;
      logic pass_end;
      logic settled;
   } graph_sts_type;

   // Sequencer to stack unit.
   typedef struct packed {
      logic look;
      logic push;
      logic pop;
   } stack_ctl_type;

endpackage

`default_nettype wire

### rtl/core/lod_if.sv
// Valid/ready channel interfaces for event requests and status responses.
`timescale 1ns / 1ps
`default_nettype none

interface lod_req_if import lod_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [CMD_W-1:0]    cmd;
   logic [THREAD_W-1:0] thread_id;
   logic [KEY_W-1:0]    lock_key;

   modport source (output valid, cmd, thread_id, lock_key, input ready);
   modport sink   (input valid, cmd, thread_id, lock_key, output ready);
endinterface

interface lod_rsp_if import lod_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;

   modport source (output valid, status, input ready);
   modport sink   (input valid, status, output ready);
endinterface

`default_nettype wire

### rtl/core/lock_order_deadlock_checker.sv
// Top level: event sequencer of the lock order deadlock checker.
`timescale 1ns / 1ps
`default_nettype none

// Checks acquire/release transactions against per-thread held-lock stacks and
// a global lock-order graph. One transaction is in flight at a time: req ready
// is high only while the block is idle, and the single status response is held
// on rsp until taken. A release, a relock, a known edge or a push onto an
// empty stack goes through the look and decide states to the response, with a
// push state in between where the stack grows. A new edge starts the
// reachability walk, which reads one graph row per cycle in passes over all
// NUM_LOCKS rows until the top lock is reached or a pass adds nothing; a new
// edge that raises no cycle then goes on to the push state. Any error status
// halts the block; every later transaction answers halted until reset.
module lock_order_deadlock_checker import lod_pkg::*; #(
   parameter int NUM_LOCKS   = LOD_NUM_LOCKS,
   parameter int NUM_THREADS = LOD_NUM_THREADS,
   parameter int STACK_DEPTH = LOD_STACK_DEPTH
) (
   input wire logic   clock,
   input wire logic   reset,
   lod_req_if.sink    req_ch,
   lod_rsp_if.source  rsp_ch
);

   localparam int LOCK_W = $clog2(NUM_LOCKS);
   localparam int THR_W  = (NUM_THREADS > 1) ? $clog2(NUM_THREADS) : 1;
   localparam int DEP_W  = $clog2(STACK_DEPTH + 1);

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_LOOK   = 6'b000010,
      S_DECIDE = 6'b000100,
      S_WALK   = 6'b001000,
      S_PUSH   = 6'b010000,
      S_RESP   = 6'b100000
   } state_type;

   state_type         state_ff, state_in;
   logic              cmd_ff, cmd_in;
   logic [THR_W-1:0]  thr_ff, thr_in;
   logic [LOCK_W-1:0] key_ff, key_in;
   status_type        status_ff, status_in;
   logic              halted_ff, halted_in;

   logic [THREAD_W-1:0] thr_red;
   logic [KEY_W-1:0]    key_red;
   logic                req_fire;

   graph_ctl_type     g_ctl;
   graph_sts_type     g_sts;
   stack_ctl_type     s_ctl;
   logic [DEP_W-1:0]  depth;
   logic [LOCK_W-1:0] top_key;

   lod_graph #(
      .NUM_LOCKS (NUM_LOCKS)
   ) u_graph (
      .clock (clock),
      .reset (reset),
      .ctl_i (g_ctl),
      .top_i (top_key),
      .key_i (key_ff),
      .sts_o (g_sts)
   );

   lod_stack #(
      .NUM_LOCKS   (NUM_LOCKS),
      .NUM_THREADS (NUM_THREADS),
      .STACK_DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock    (clock),
      .reset    (reset),
      .ctl_i    (s_ctl),
      .thread_i (thr_ff),
      .key_i    (key_ff),
      .depth_o  (depth),
      .top_o    (top_key)
   );

   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign rsp_ch.valid = (state_ff == S_RESP);
   assign rsp_ch.status = status_ff;

   // Out-of-range thread and lock ids wrap modulo the configured counts.
   always_comb begin
      thr_red = req_ch.thread_id;
      key_red = req_ch.lock_key;
      for (int i = 0; i < 7; i++) begin
         if (int'(thr_red) >= NUM_THREADS) begin
            thr_red = thr_red - THREAD_W'(NUM_THREADS);
         end
         if (int'(key_red) >= NUM_LOCKS) begin
            key_red = key_red - KEY_W'(NUM_LOCKS);
         end
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd_in    = cmd_ff;
      thr_in    = thr_ff;
      key_in    = key_ff;
      status_in = status_ff;
      halted_in = halted_ff;
      g_ctl     = '0;
      s_ctl     = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               cmd_in = req_ch.cmd;
               thr_in = THR_W'(thr_red);
               key_in = LOCK_W'(key_red);
               if (halted_ff) begin
                  status_in = ST_HALTED;
                  state_in  = S_RESP;
               end else begin
                  state_in = S_LOOK;
               end
            end
         end
         S_LOOK: begin
            s_ctl.look = 1'b1;
            state_in   = S_DECIDE;
         end
         S_DECIDE: begin
            state_in = S_RESP;
            if (cmd_ff == CMD_RELEASE) begin
               priority if (depth == '0) begin
                  status_in = ST_POP_EMPTY;
               end else if (top_key != key_ff) begin
                  status_in = ST_POP_NOT_TOP;
               end else begin
                  s_ctl.pop = 1'b1;
                  status_in = ST_OK;
               end
            end else begin
               priority if (depth == '0) begin
                  state_in = S_PUSH;
               end else if (top_key == key_ff) begin
                  status_in = ST_RELOCK;
               end else if (!g_sts.edge_known) begin
                  g_ctl.set_edge   = 1'b1;
                  g_ctl.walk_start = 1'b1;
                  state_in         = S_WALK;
               end else begin
                  state_in = S_PUSH;
               end
            end
            halted_in = (state_in == S_RESP) && (status_in != ST_OK);
         end
         S_WALK: begin
            g_ctl.walk_step = 1'b1;
            priority if (g_sts.found) begin
               status_in = ST_CYCLE;
               halted_in = 1'b1;
               state_in  = S_RESP;
            end else if (g_sts.pass_end && g_sts.settled) begin
               state_in = S_PUSH;
            end
         end
         S_PUSH: begin
            state_in = S_RESP;
            if (depth == DEP_W'(STACK_DEPTH)) begin
               status_in = ST_FULL;
               halted_in = 1'b1;
            end else begin
               s_ctl.push = 1'b1;
               status_in  = ST_OK;
            end
         end
         S_RESP: begin
            if (rsp_ch.ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         halted_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         halted_ff <= halted_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      thr_ff    <= thr_in;
      key_ff    <= key_in;
      status_ff <= status_in;
   end

   // A pending response blocks new transactions.
   a_no_accept_while_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> !req_ch.ready)
      else $error("request accepted while a response is pending");

   // Halt is sticky.
   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      halted_ff |=> halted_ff)
      else $error("halt flag cleared without reset");

   // Any error response comes with the halt flag already set.
   a_error_halts: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && status_ff != ST_OK) |-> halted_ff)
      else $error("error status without halt");

   // A transaction taken while halted answers halted on the next cycle.
   a_halted_answer: assert property (@(posedge clock) disable iff (reset)
      (req_fire && halted_ff) |=> (rsp_ch.valid && status_ff == ST_HALTED))
      else $error("halted block gave a non-halted answer");

   // The walk only runs for an acquire that found a non-empty stack.
   a_walk_acquire: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WALK) |-> (cmd_ff == CMD_ACQUIRE && depth != '0))
      else $error("walk running outside an acquire");

endmodule

`default_nettype wire

### rtl/core/lod_graph.sv
// Lock-order edge matrix and the row-at-a-time reachability walk unit.
`timescale 1ns / 1ps
`default_nettype none

module lod_graph import lod_pkg::*; #(
   parameter int NUM_LOCKS = LOD_NUM_LOCKS,
   localparam int LOCK_W   = $clog2(NUM_LOCKS)
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire graph_ctl_type     ctl_i,
   input  wire logic [LOCK_W-1:0] top_i,
   input  wire logic [LOCK_W-1:0] key_i,
   output      graph_sts_type     sts_o
);

   logic [NUM_LOCKS-1:0] edges_ff [NUM_LOCKS];
   logic [NUM_LOCKS-1:0] visited_ff;
   logic [NUM_LOCKS-1:0] visited_in;
   logic [NUM_LOCKS-1:0] grown;
   logic [LOCK_W-1:0]    idx_ff;
   logic [LOCK_W-1:0]    idx_in;
   logic                 changed_ff;
   logic                 changed_in;
   logic                 pass_end;

   // One row per cycle while walk_step is set: fold the row's successors in if the row is reached.
   always_comb begin
      grown    = visited_ff | (visited_ff[idx_ff] ? edges_ff[idx_ff] : '0);
      pass_end = (idx_ff == LOCK_W'(NUM_LOCKS - 1));

      sts_o.edge_known = edges_ff[top_i][key_i];
      sts_o.found      = grown[top_i];
      sts_o.pass_end   = pass_end;
      sts_o.settled    = !changed_ff && (grown == visited_ff);

      visited_in = visited_ff;
      idx_in     = idx_ff;
      changed_in = changed_ff;
      if (ctl_i.walk_start) begin
         visited_in = NUM_LOCKS'(1) << key_i;
         idx_in     = '0;
         changed_in = 1'b0;
      end else if (ctl_i.walk_step) begin
         visited_in = grown;
         if (pass_end) begin
            idx_in     = '0;
            changed_in = 1'b0;
         end else begin
            idx_in     = idx_ff + 1'b1;
            changed_in = changed_ff | (grown != visited_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_LOCKS; i++) begin
            edges_ff[i] <= '0;
         end
         visited_ff <= '0;
         idx_ff     <= '0;
         changed_ff <= 1'b0;
      end else begin
         if (ctl_i.set_edge) begin
            edges_ff[top_i][key_i] <= 1'b1;
         end
         visited_ff <= visited_in;
         idx_ff     <= idx_in;
         changed_ff <= changed_in;
      end
   end

endmodule

`default_nettype wire

### rtl/core/lod_stack.sv
// Per-thread held-lock stacks: depth counters and the stack entry memory.
`timescale 1ns / 1ps
`default_nettype none

module lod_stack import lod_pkg::*; #(
   parameter int NUM_LOCKS   = LOD_NUM_LOCKS,
   parameter int NUM_THREADS = LOD_NUM_THREADS,
   parameter int STACK_DEPTH = LOD_STACK_DEPTH,
   localparam int LOCK_W     = $clog2(NUM_LOCKS),
   localparam int THR_W      = (NUM_THREADS > 1) ? $clog2(NUM_THREADS) : 1,
   localparam int DEP_W      = $clog2(STACK_DEPTH + 1)
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire stack_ctl_type     ctl_i,
   input  wire logic [THR_W-1:0]  thread_i,
   input  wire logic [LOCK_W-1:0] key_i,
   output      logic [DEP_W-1:0]  depth_o,
   output      logic [LOCK_W-1:0] top_o
);

   localparam int ENTRIES = NUM_THREADS * STACK_DEPTH;
   localparam int ADDR_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

   logic [LOCK_W-1:0] stack_mem [ENTRIES];
   logic [DEP_W-1:0]  depths_ff [NUM_THREADS];
   logic [LOCK_W-1:0] top_ff;
   logic [ADDR_W-1:0] base;
   logic [ADDR_W-1:0] top_addr;
   logic [ADDR_W-1:0] wr_addr;

   always_comb begin
      depth_o  = depths_ff[thread_i];
      base     = ADDR_W'(int'(thread_i) * STACK_DEPTH);
      // An empty stack has no top; read the base entry, the value is unused.
      top_addr = base + ((depth_o == '0) ? '0 : ADDR_W'(depth_o - 1'b1));
      wr_addr  = base + ADDR_W'(depth_o);
   end

   assign top_o = top_ff;

   always_ff @(posedge clock) begin
      if (ctl_i.push) begin
         stack_mem[wr_addr] <= key_i;
      end
      if (ctl_i.look) begin
         top_ff <= stack_mem[top_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_THREADS; i++) begin
            depths_ff[i] <= '0;
         end
      end else if (ctl_i.push) begin
         depths_ff[thread_i] <= depth_o + 1'b1;
      end else if (ctl_i.pop) begin
         depths_ff[thread_i] <= depth_o - 1'b1;
      end
   end

endmodule

`default_nettype wire
